// ===== rtl/bbm_pkg.sv =====
// Package for the bounding box merge block: field widths, box record type
// and defaults. Used by every module of the block; depends on nothing.
`default_nettype none

package bbm_pkg;

    localparam int X_W      = 12;
    localparam int Y_W      = 12;
    localparam int W_W      = 13;
    localparam int H_W      = 13;
    localparam int PAD_W    = 10;
    localparam int BOX_W    = X_W + Y_W + W_W + H_W;       // 50
    localparam int DATA_W   = ((BOX_W + 7) / 8) * 8;        // 56
    // right/bottom edge of a box (coordinate + size)
    localparam int EDGE_W   = 14;
    // right/bottom edge of a padded box (coordinate + size + padding)
    localparam int SPAN_W   = 15;

    localparam int MAX_BOXES_DEF = 64;

    localparam logic [W_W-1:0] SIZE_SAT = {W_W{1'b1}};

    typedef struct packed {
        logic [H_W-1:0] h;
        logic [W_W-1:0] w;
        logic [Y_W-1:0] y;
        logic [X_W-1:0] x;
    } box_t;

    // result of comparing one stored pair
    typedef struct packed {
        logic hit;      // box a grown by the padding overlaps box b with positive area
        box_t joined;   // union bounding box of the pair
    } pair_res_t;

endpackage

`default_nettype wire

// ===== rtl/bbm_store.sv =====
// Box store: single-write, single-read synchronous memory with a registered
// read port. Depends on bbm_pkg for the box record.
`default_nettype none

module bbm_store #(
    parameter int DEPTH  = bbm_pkg::MAX_BOXES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire bbm_pkg::box_t     wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output bbm_pkg::box_t          rd_data
);

    bbm_pkg::box_t mem [DEPTH];
    bbm_pkg::box_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/bbm_geom.sv =====
// Pair geometry: padded overlap test of box a against box b, and the union
// bounding box with size saturation. Depends on bbm_pkg.
`default_nettype none

module bbm_geom (
    input  wire bbm_pkg::box_t           box_a,
    input  wire bbm_pkg::box_t           box_b,
    input  wire logic [bbm_pkg::PAD_W-1:0] pad,
    output bbm_pkg::pair_res_t           res
);

    localparam int SW = bbm_pkg::SPAN_W;
    localparam int EW = bbm_pkg::EDGE_W;

    logic          a_empty, b_empty, a_pad_empty;
    logic [SW-1:0] ax_hi, ay_hi, bx_hi, by_hi, ax_lo, ay_lo;
    logic [EW-1:0] a_right, a_bottom, b_right, b_bottom;
    logic [EW-1:0] r_x, r_y, r_right, r_bottom, r_w, r_h;

    always_comb begin
        a_empty     = (box_a.w == '0) || (box_a.h == '0);
        b_empty     = (box_b.w == '0) || (box_b.h == '0);
        // padded box is degenerate only when padding is zero too
        a_pad_empty = ((box_a.w == '0) || (box_a.h == '0)) && (pad == '0);

        // padded a spans (x-pad, x+w+pad); test x+w+pad > bx and bx+bw+pad > ax
        ax_hi = SW'(box_a.x) + SW'(box_a.w) + SW'(pad);
        ay_hi = SW'(box_a.y) + SW'(box_a.h) + SW'(pad);
        bx_hi = SW'(box_b.x) + SW'(box_b.w) + SW'(pad);
        by_hi = SW'(box_b.y) + SW'(box_b.h) + SW'(pad);
        ax_lo = SW'(box_a.x);
        ay_lo = SW'(box_a.y);

        res.hit = !a_pad_empty && !b_empty
                  && (ax_hi > SW'(box_b.x)) && (bx_hi > ax_lo)
                  && (ay_hi > SW'(box_b.y)) && (by_hi > ay_lo);

        a_right  = EW'(box_a.x) + EW'(box_a.w);
        a_bottom = EW'(box_a.y) + EW'(box_a.h);
        b_right  = EW'(box_b.x) + EW'(box_b.w);
        b_bottom = EW'(box_b.y) + EW'(box_b.h);

        r_x      = (box_a.x < box_b.x) ? EW'(box_a.x) : EW'(box_b.x);
        r_y      = (box_a.y < box_b.y) ? EW'(box_a.y) : EW'(box_b.y);
        r_right  = (a_right > b_right)   ? a_right  : b_right;
        r_bottom = (a_bottom > b_bottom) ? a_bottom : b_bottom;
        r_w      = r_right - r_x;
        r_h      = r_bottom - r_y;

        if (a_empty) begin
            res.joined = box_b;
        end else if (b_empty) begin
            res.joined = box_a;
        end else begin
            res.joined.x = r_x[bbm_pkg::X_W-1:0];
            res.joined.y = r_y[bbm_pkg::Y_W-1:0];
            res.joined.w = (r_w > EW'(bbm_pkg::SIZE_SAT)) ? bbm_pkg::SIZE_SAT
                                                          : r_w[bbm_pkg::W_W-1:0];
            res.joined.h = (r_h > EW'(bbm_pkg::SIZE_SAT)) ? bbm_pkg::SIZE_SAT
                                                          : r_h[bbm_pkg::H_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bounding_box_merge_top.sv =====
// Top level of the bounding box merge block: stream ports, config register
// and the merge sequencer. Depends on bbm_pkg, bbm_store and bbm_geom.
`default_nettype none

// Boxes arrive one per item and are written into an on-chip store of
// MAX_BOXES entries; boxes past capacity are dropped and every result of
// that set carries overflow_flag. The item with tlast set closes the set
// and starts merging: the sequencer holds box i in a register and streams
// boxes i+1.. through the single read port of the store, one pair test per
// cycle after S_FETCH_I and S_LATCH_I start each row i. The first pair that
// overlaps (box i grown by merge_padding on every side) is replaced by its
// union, later entries move down one place, and the search restarts at
// row 0. With N boxes in the set, each merge removes one entry before the
// restart, so the whole merge phase is bounded by roughly N passes. Results
// then leave in order, each read from the store in S_EMIT_LD and offered in
// S_EMIT until the sink is ready; the last one carries tlast. No item is
// accepted between the closing item and the last result. merge_padding may
// be written only while the block is idle; its channel is always ready. The
// store needs no clearing after reset.
module bounding_box_merge_top #(
    parameter int MAX_BOXES = bbm_pkg::MAX_BOXES_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input boxes
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [11:0] box_x, [23:12] box_y, [36:24] box_width, [49:37] box_height
    input  wire logic [bbm_pkg::DATA_W-1:0] s_tdata,
    input  wire logic                       s_tlast,    // is_last_box
    // merged boxes
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [11:0] out_x, [23:12] out_y, [36:24] out_width, [49:37] out_height
    output logic [bbm_pkg::DATA_W-1:0]      m_tdata,
    output logic                            m_tlast,    // is_last_result
    output logic                            m_tuser,    // [0] overflow_flag
    // merge_padding register write
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [bbm_pkg::PAD_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(MAX_BOXES);
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    typedef enum logic [6:0] {
        S_LOAD    = 7'b0000001,  // taking boxes
        S_FETCH_I = 7'b0000010,  // read box i, or finish merging
        S_LATCH_I = 7'b0000100,  // hold box i, read box i+1
        S_TEST    = 7'b0001000,  // test box i against box j
        S_SHIFT   = 7'b0010000,  // close the gap left by box j
        S_EMIT_LD = 7'b0100000,  // result data arriving from store
        S_EMIT    = 7'b1000000   // result offered on the master side
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [bbm_pkg::PAD_W-1:0] pad_reg;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    bbm_pkg::box_t        box_i_reg, box_i_next;
    bbm_pkg::box_t        out_box_reg, out_box_next;
    logic                 out_last_reg, out_last_next;

    // store access
    logic                 wr_en, rd_en;
    logic [CNT_W-1:0]     wr_idx, rd_idx;
    bbm_pkg::box_t        wr_data, rd_data, in_box;
    bbm_pkg::pair_res_t   pair;

    logic                 s_fire, m_fire;

    assign in_box   = bbm_pkg::box_t'(s_tdata[bbm_pkg::BOX_W-1:0]);
    assign s_tready = (state_reg == S_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_EMIT);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = {{(bbm_pkg::DATA_W - bbm_pkg::BOX_W){1'b0}}, out_box_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = ovf_reg;
    assign cfg_ready = 1'b1;

    bbm_store #(
        .DEPTH  (MAX_BOXES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    bbm_geom u_geom (
        .box_a (box_i_reg),
        .box_b (rd_data),
        .pad   (pad_reg),
        .res   (pair)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        box_i_next    = box_i_reg;
        out_box_next  = out_box_reg;
        out_last_next = out_last_reg;
        wr_en         = 1'b0;
        wr_idx        = count_reg;
        wr_data       = in_box;
        rd_en         = 1'b0;
        rd_idx        = i_reg;

        unique case (state_reg)
            S_LOAD: begin
                if (s_fire) begin
                    if (count_reg < CNT_MAX) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_ONE;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        i_next     = '0;
                        state_next = S_FETCH_I;
                    end
                end
            end
            S_FETCH_I: begin
                rd_en = 1'b1;
                if (i_reg + CNT_ONE >= count_reg) begin
                    // no pair left to test: start output at entry 0
                    rd_idx     = '0;
                    k_next     = '0;
                    state_next = S_EMIT_LD;
                end else begin
                    rd_idx     = i_reg;
                    state_next = S_LATCH_I;
                end
            end
            S_LATCH_I: begin
                box_i_next = rd_data;
                rd_en      = 1'b1;
                rd_idx     = i_reg + CNT_ONE;
                j_next     = i_reg + CNT_ONE;
                state_next = S_TEST;
            end
            S_TEST: begin
                if (pair.hit) begin
                    wr_en   = 1'b1;
                    wr_idx  = i_reg;
                    wr_data = pair.joined;
                    if (j_reg + CNT_ONE < count_reg) begin
                        rd_en      = 1'b1;
                        rd_idx     = j_reg + CNT_ONE;
                        k_next     = j_reg;
                        state_next = S_SHIFT;
                    end else begin
                        count_next = count_reg - CNT_ONE;
                        i_next     = '0;
                        state_next = S_FETCH_I;
                    end
                end else if (j_reg + CNT_ONE < count_reg) begin
                    rd_en  = 1'b1;
                    rd_idx = j_reg + CNT_ONE;
                    j_next = j_reg + CNT_ONE;
                end else begin
                    i_next     = i_reg + CNT_ONE;
                    state_next = S_FETCH_I;
                end
            end
            S_SHIFT: begin
                // rd_data holds entry k+1
                wr_en   = 1'b1;
                wr_idx  = k_reg;
                wr_data = rd_data;
                if (k_reg + CNT_TWO < count_reg) begin
                    rd_en  = 1'b1;
                    rd_idx = k_reg + CNT_TWO;
                    k_next = k_reg + CNT_ONE;
                end else begin
                    count_next = count_reg - CNT_ONE;
                    i_next     = '0;
                    state_next = S_FETCH_I;
                end
            end
            S_EMIT_LD: begin
                out_box_next  = rd_data;
                out_last_next = (k_reg + CNT_ONE == count_reg);
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (m_fire) begin
                    if (out_last_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        rd_en      = 1'b1;
                        rd_idx     = k_reg + CNT_ONE;
                        k_next     = k_reg + CNT_ONE;
                        state_next = S_EMIT_LD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            pad_reg      <= '0;
            out_last_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            out_last_reg <= out_last_next;
            if (cfg_valid && cfg_ready) begin
                pad_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        box_i_reg   <= box_i_next;
        out_box_reg <= out_box_next;
    end

    // store never holds more boxes than it has entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("box count above capacity");

    // overflow is raised only by an item arriving at a full store
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovf_reg) |-> $past(s_fire) && ($past(count_reg) == CNT_MAX))
        else $error("overflow set without a full store");

    // a set never ends empty, and results only come from stored boxes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (count_reg != '0) && (k_reg < count_reg))
        else $error("result offered from an empty or short store");

    // the final result empties the set and reopens the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && m_tlast |=> s_tready && (count_reg == '0) && !ovf_reg)
        else $error("set not cleared after final result");

    // no read of an entry in the cycle it is written
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && rd_en |-> wr_idx != rd_idx)
        else $error("store read and write collide");

endmodule

`default_nettype wire
